/* sv/scalar_kalman_per_channel_core_assert.svh */
// Assertion macros used by the checker of this block.
`ifndef SCALAR_KALMAN_PER_CHANNEL_CORE_ASSERT_SVH
`define SCALAR_KALMAN_PER_CHANNEL_CORE_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define SKPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent, outside reset.
`define SKPC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent, reset included.
`define SKPC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/skpc_pkg.sv */
`default_nettype none

package skpc_pkg;

    localparam int CHANNELS_DEF      = 16;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int SAMPLE_W   = 16;
    localparam int CH_W       = 4;
    localparam int VAR_W      = 32;
    localparam int OBS_CFG_W  = 24;
    localparam int APB_W      = 32;
    localparam int PADDR_W    = 3;

    // Word index of the observation noise register (byte address 4*index).
    localparam logic REG_OBS_NOISE = 1'b0;

    // Process noise constants in hundredths; scaled to Q6.F at elaboration.
    localparam int NOISE_COUNT    = 16;
    localparam int NOISE_INT_BITS = 6;
    localparam int NOISE_SCALE    = 100;
    localparam logic [15:0] NOISE_HUNDREDTHS [NOISE_COUNT] = '{
        16'd2560, 16'd1746, 16'd1149, 16'd1558, 16'd2636, 16'd2774, 16'd2441, 16'd3396,
        16'd4014, 16'd2910, 16'd1245, 16'd1159, 16'd1290, 16'd1035, 16'd3754, 16'd2245
    };

    // Round-to-nearest scaling of a constant in hundredths to f fraction bits.
    function automatic logic [63:0] noise_q(input logic [15:0] h, input int f);
        noise_q = ((64'(h) << f) + 64'd50) / 64'(NOISE_SCALE);
    endfunction

endpackage

`default_nettype wire

/* sv/scalar_kalman_per_channel_core.sv */
// Per-channel scalar Kalman filter.
//
// Input channel (i_in_valid / o_in_stall): one item is a raw sample, the
// previous estimate and a channel number; it is taken at an edge with
// i_in_valid high and o_in_stall low. Output channel (o_out_valid /
// i_out_stall): one item with the new estimate for every input item, in order.
// The APB port holds the observation noise R (Q(24-F).F, Q8.16 at F = 16) at byte address 0.
//
// One item is worked on at a time. The gain comes from a restoring divider
// that yields one quotient bit per cycle, and both products (gain times
// innovation, gain times predicted variance) build up bit-serially behind it,
// so the FRACTION_BITS + 1 divider steps set the time from accept to the next
// accept. o_out_valid rises once the RESULT state has loaded the output register.
// An item with a channel of CHANNELS or above goes from READ straight to RESULT
// and returns the previous estimate unchanged. The result sits in an output
// register, so a stalled receiver does not hold the datapath until the next
// result is due.
//
// Reset restores R to 1.0 and marks every variance entry as 1.0 through a
// per-entry valid bit; no clearing pass is needed and items are taken at once.

`default_nettype none

module scalar_kalman_per_channel_core
    import skpc_pkg::*;
#(
    parameter int CHANNELS      = CHANNELS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // input items
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic signed [SAMPLE_W-1:0] i_raw_sample,
    input  wire logic signed [SAMPLE_W-1:0] i_previous_estimate,
    input  wire logic        [CH_W-1:0]     i_channel,
    // result items
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic signed      [SAMPLE_W-1:0] o_estimate,
    // configuration
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic        [PADDR_W-1:0]  paddr,
    input  wire logic        [APB_W-1:0]    pwdata,
    output logic             [APB_W-1:0]    prdata,
    output logic                            pready
);

    localparam int IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int K_W     = FRACTION_BITS + 1;
    localparam int NOISE_W = NOISE_INT_BITS + FRACTION_BITS;
    localparam int OBS_W   = (FRACTION_BITS >= OBS_CFG_W) ? FRACTION_BITS + 1 : OBS_CFG_W;
    localparam int DEN_W   = VAR_W + 1;
    localparam int REM_W   = VAR_W + 2;
    localparam int DIFF_W  = SAMPLE_W + 1;
    localparam int DK_W    = DIFF_W + K_W + 1;
    localparam int ACC_W   = DK_W + 1;
    localparam int KP_W    = VAR_W + K_W;
    localparam int CNT_W   = $clog2(FRACTION_BITS + 1);

    localparam logic [VAR_W-1:0] ONE_VAR  = VAR_W'(64'd1 << FRACTION_BITS);
    localparam logic [OBS_W-1:0] ONE_OBS  = OBS_W'(64'd1 << FRACTION_BITS);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(FRACTION_BITS);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_READ   = 7'b0000010,
        S_PREP   = 7'b0000100,
        S_DIV    = 7'b0001000,
        S_TAIL   = 7'b0010000,
        S_FINISH = 7'b0100000,
        S_RESULT = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // item context
    logic        [CH_W-1:0]   r_channel;
    logic                     r_skip;
    logic signed [SAMPLE_W-1:0] r_prev;
    logic signed [DIFF_W-1:0] r_diff;

    // prediction and divider
    logic [VAR_W-1:0] r_pt;
    logic [DEN_W-1:0] r_den;
    logic             r_den_zero;
    logic [REM_W-1:0] r_rem;
    logic             r_qbit;
    logic [CNT_W-1:0] r_cnt;

    // bit-serial products and final sum
    logic signed [DK_W-1:0]  r_dk;
    logic        [KP_W-1:0]  r_kp;
    logic signed [ACC_W-1:0] r_acc;

    logic [CHANNELS-1:0] r_valid;
    logic [OBS_W-1:0]    r_obs_noise;

    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_estimate;

    logic [NOISE_W-1:0] w_noise_rom [NOISE_COUNT];

    logic               w_accept;
    logic               w_in_skip;
    logic               w_out_free;
    logic               w_cfg_we;
    logic [IDX_W-1:0]   w_idx;
    logic [IDX_W-1:0]   w_in_idx;
    logic [VAR_W-1:0]   w_ram_rdata;
    logic [VAR_W-1:0]   w_prior;
    logic [DEN_W-1:0]   w_pt_sum;
    logic [VAR_W-1:0]   w_pt_sat;
    logic               w_bit;
    logic [REM_W-1:0]   w_rem_after;
    logic signed [DK_W-1:0]  w_diff_ext;
    logic signed [DK_W-1:0]  w_dk_add;
    logic [KP_W-1:0]         w_kp_add;
    logic signed [ACC_W-1:0] w_prev_ext;
    logic signed [ACC_W-1:0] w_dk_ext;
    logic [KP_W-1:0]         w_var_full;
    logic [VAR_W-1:0]        w_var_new;
    logic signed [ACC_W-1:0] w_acc_shift;
    logic                    w_round;
    logic signed [SAMPLE_W-1:0] w_est;

    // Process noise constants, fixed at elaboration.
    for (genvar g = 0; g < NOISE_COUNT; g++) begin : g_noise
        assign w_noise_rom[g] = NOISE_W'(noise_q(NOISE_HUNDREDTHS[g], FRACTION_BITS));
    end

    // ---------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_in_skip  = 32'(i_channel) >= 32'(CHANNELS);
    // Output register can take a new result when empty or being drained.
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_estimate  = r_estimate;

    // ---------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && (paddr[2] == REG_OBS_NOISE);
    assign prdata   = (paddr[2] == REG_OBS_NOISE) ? APB_W'(r_obs_noise) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obs_noise <= ONE_OBS;
        end else if (w_cfg_we) begin
            r_obs_noise <= OBS_W'(pwdata[OBS_CFG_W-1:0]);
        end
    end

    // ---------------------------------------------------------------
    // Variance store: RAM plus a valid bit per entry; an entry never
    // written since reset reads as 1.0.
    // ---------------------------------------------------------------
    assign w_idx    = IDX_W'(r_channel);
    assign w_in_idx = IDX_W'(i_channel);

    skpc_ram #(
        .WIDTH (VAR_W),
        .DEPTH (CHANNELS)
    ) u_var_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_FINISH),
        .i_waddr (w_idx),
        .i_wdata (w_var_new),
        .i_re    (w_accept),
        .i_raddr (w_in_idx),
        .o_rdata (w_ram_rdata)
    );

    assign w_prior  = r_valid[w_idx] ? w_ram_rdata : ONE_VAR;

    // Predict: Pt = P + Q, saturating at all ones.
    assign w_pt_sum = DEN_W'(w_prior) + DEN_W'(w_noise_rom[r_channel]);
    assign w_pt_sat = w_pt_sum[VAR_W] ? '1 : w_pt_sum[VAR_W-1:0];

    // ---------------------------------------------------------------
    // Restoring divider step: one gain bit, MSB first. Pt < Pt + R except
    // when R is zero, so the first step yields the integer bit of the gain.
    // A zero denominator forces every bit to zero.
    // ---------------------------------------------------------------
    assign w_bit       = (r_rem >= REM_W'(r_den)) && !r_den_zero;
    assign w_rem_after = w_bit ? (r_rem - REM_W'(r_den)) : r_rem;

    // Horner accumulation of K*(raw - prev) and K*Pt, one registered bit behind.
    assign w_diff_ext = DK_W'(r_diff);
    assign w_dk_add   = r_qbit ? w_diff_ext : DK_W'(0);
    assign w_kp_add   = r_qbit ? KP_W'(r_pt) : KP_W'(0);

    // Estimate sum and new variance (2^F - K) * Pt / 2^F, floored.
    assign w_prev_ext = ACC_W'(r_prev);
    assign w_dk_ext   = ACC_W'(r_dk);
    assign w_var_full = (KP_W'(r_pt) << FRACTION_BITS) - r_kp;
    assign w_var_new  = w_var_full[FRACTION_BITS +: VAR_W];

    // Divide by 2^F toward zero: bump negative sums with a nonzero fraction.
    assign w_acc_shift = r_acc >>> FRACTION_BITS;
    assign w_round     = r_acc[ACC_W-1] && (|r_acc[FRACTION_BITS-1:0]);
    assign w_est       = w_acc_shift[SAMPLE_W-1:0] + SAMPLE_W'(w_round);

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = r_skip ? S_RESULT : S_PREP;
            end
            S_PREP: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_cnt == LAST_BIT) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_PREP) begin
                r_cnt <= '0;
            end else if (r_state == S_DIV) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (r_state == S_FINISH) begin
                r_valid[w_idx] <= 1'b1;
            end
            if ((r_state == S_RESULT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers: loaded by the sequencer, no reset needed.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_channel <= i_channel;
            r_skip    <= w_in_skip;
            r_prev    <= i_previous_estimate;
            r_diff    <= DIFF_W'(i_raw_sample) - DIFF_W'(i_previous_estimate);
        end
        unique case (r_state)
            S_READ: begin
                // Skipped items leave with the previous estimate as is.
                r_pt  <= w_pt_sat;
                r_acc <= w_prev_ext <<< FRACTION_BITS;
            end
            S_PREP: begin
                r_den      <= DEN_W'(r_pt) + DEN_W'(r_obs_noise);
                r_den_zero <= (r_pt == '0) && (r_obs_noise == '0);
                r_rem      <= REM_W'(r_pt);
                r_qbit     <= 1'b0;
                r_dk       <= '0;
                r_kp       <= '0;
            end
            S_DIV: begin
                r_rem  <= w_rem_after << 1;
                r_qbit <= w_bit;
                r_dk   <= (r_dk <<< 1) + w_dk_add;
                r_kp   <= (r_kp << 1) + w_kp_add;
            end
            S_TAIL: begin
                r_dk <= (r_dk <<< 1) + w_dk_add;
                r_kp <= (r_kp << 1) + w_kp_add;
            end
            S_FINISH: begin
                r_acc <= (w_prev_ext <<< FRACTION_BITS) + w_dk_ext;
            end
            S_RESULT: begin
                if (w_out_free) begin
                    r_estimate <= w_est;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/skpc_ram.sv */
`default_nettype none

module skpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* sv/skpc_checker.sv */
`default_nettype none

`include "scalar_kalman_per_channel_core_assert.svh"

module skpc_checker
    import skpc_pkg::*;
(
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       o_in_stall,
    input wire logic                       o_out_valid,
    input wire logic                       i_out_stall,
    input wire logic signed [SAMPLE_W-1:0] o_estimate,
    input wire logic                       pready
);

    // A stalled result holds its value.
    `SKPC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_estimate), "stalled result changed")

    // One item at a time: an accepted item closes the input.
    `SKPC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input open right after accept")

    // A new result only appears while an item is being worked on.
    `SKPC_ASSERT_SAME(a_result_from_work, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall), "result without work")

    // Reset leaves the block idle and empty.
    `SKPC_ASSERT_NEXT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !o_out_valid && !o_in_stall && pready, "not idle after reset")

endmodule

bind scalar_kalman_per_channel_core skpc_checker u_skpc_checker (.*);

`default_nettype wire
